>>> rtl/core/jqp_pkg.sv
// shared types and constants of the joystick quadrature pulse planner
package jqp_pkg;

    localparam int DEAD_W     = 12;
    localparam int CAP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CAP = 2'd2;

    localparam logic [DEAD_W-1:0] DEAD_LOW_RST  = 12'd1300;
    localparam logic [DEAD_W-1:0] DEAD_HIGH_RST = 12'd2400;
    localparam logic [CAP_W-1:0]  PULSE_CAP_RST = 8'd65;

    localparam int NDIR   = 4;
    localparam int NSLOT  = 8;
    localparam int SLOT_W = 3;

    localparam int DIR_LEFT  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_UP    = 3;

    // low side: s = 65 * (sample + 1300 - dead_low) / 633, t = 65 * (133 - s) / 68
    localparam int LOW_OFS  = 1300;
    localparam int SCALE    = 65;
    localparam int S_BIAS   = 133;
    localparam int LOW_DEN  = 68;
    // high side: t = 65 * (sample - dead_high - 100) / 800
    localparam int HIGH_OFS = 100;
    localparam int HIGH_DEN = 800;

    // ceil(2^33 / 633), exact quotient for dividends below 2^23
    localparam int              RECIP_W     = 24;
    localparam int              RECIP_SHIFT = 33;
    localparam logic [RECIP_W-1:0] RECIP_633 = 24'd13570197;

    typedef struct packed {
        logic [DEAD_W-1:0] dead_low;
        logic [DEAD_W-1:0] dead_high;
        logic [CAP_W-1:0]  pulse_cap;
    } t_cfg;

    typedef struct packed {
        logic [NDIR-1:0] fwd_act;
        logic [NDIR-1:0] rev_ok;
        logic            sw;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

>>> rtl/core/jqp_fifo.sv
// short decoupling queue between the classify front and the burst back end
module jqp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [NW-1:0]    r_num;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_num == NW'(DEPTH));
    assign o_valid = (r_num != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_num <= r_num + 1'b1;
            end else if (do_pop && !do_push) begin
                r_num <= r_num - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/jqp_front.sv
// front end: accepts a polling pass, classifies directions, computes target metrics
module jqp_front #(
    parameter int SAMPLE_BITS = 12,
    localparam int WU = ((SAMPLE_BITS > jqp_pkg::DEAD_W) ? SAMPLE_BITS : jqp_pkg::DEAD_W) + 2,
    localparam int WM = WU + 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jqp_pkg::t_cfg                 i_cfg,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [SAMPLE_BITS-1:0]        i_vert,
    input  logic [SAMPLE_BITS-1:0]        i_horiz,
    input  logic [jqp_pkg::NDIR-1:0]      i_btn,
    input  logic                          i_sw,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output jqp_pkg::t_ctl                 o_ctl,
    output logic [1:0][WM-1:0]            o_low_metric,
    output logic [1:0][WM-1:0]            o_high_metric
);
    import jqp_pkg::*;

    localparam int WY  = WU + 7;
    localparam int WA  = WU + 6;
    localparam int WP  = WA + RECIP_W;
    localparam int WSM = WP - RECIP_SHIFT;
    localparam int WS  = WSM + 1;

    logic        en;
    logic [3:0]  r_vld;

    logic [WU-1:0]        samp_w [2];
    logic [WU-1:0]        dl_w;
    logic [WU-1:0]        dh_w;
    logic [WU-1:0]        u [2];
    logic [WU-1:0]        xh [2];
    logic [1:0]           below;
    logic [1:0]           above;
    logic [1:0]           mid;
    t_ctl                 ctl_in;

    logic signed [WU-1:0] r_u [2];
    logic signed [WU-1:0] r_xh [2];
    t_ctl                 r_ctl1;

    logic signed [WY-1:0] y [2];
    logic signed [WM-1:0] hm [2];
    logic [WA-1:0]        r_abs [2];
    logic [1:0]           r_neg;
    logic signed [WM-1:0] r_hm2 [2];
    t_ctl                 r_ctl2;

    logic [WP-1:0]        prod [2];
    logic signed [WS-1:0] s_pos [2];
    logic signed [WS-1:0] s [2];
    logic signed [WS-1:0] r_s [2];
    logic signed [WM-1:0] r_hm3 [2];
    t_ctl                 r_ctl3;

    logic signed [WM-1:0] dd [2];
    logic signed [WM-1:0] lm [2];
    logic signed [WM-1:0] r_lm [2];
    logic signed [WM-1:0] r_hm4 [2];
    t_ctl                 r_ctl4;

    // the whole chain stalls together when the last stage cannot hand off
    assign en       = !(r_vld[3] && i_q_full);
    assign o_full   = !en;
    assign o_q_push = r_vld[3] && !i_q_full;
    assign o_ctl    = r_ctl4;

    always_comb begin
        samp_w[0] = WU'(i_vert);
        samp_w[1] = WU'(i_horiz);
        dl_w      = WU'(i_cfg.dead_low);
        dh_w      = WU'(i_cfg.dead_high);
        for (int k = 0; k < 2; k++) begin
            u[k]     = samp_w[k] + WU'(LOW_OFS) - dl_w;
            xh[k]    = samp_w[k] - dh_w - WU'(HIGH_OFS);
            below[k] = samp_w[k] < dl_w;
            above[k] = samp_w[k] > dh_w;
            mid[k]   = (samp_w[k] > dl_w) && (samp_w[k] < dh_w);
        end
        ctl_in.sw                = i_sw;
        ctl_in.fwd_act[DIR_LEFT]  = (!i_btn[DIR_LEFT]  && i_sw) || below[0];
        ctl_in.fwd_act[DIR_RIGHT] = (!i_btn[DIR_RIGHT] && i_sw) || above[0];
        ctl_in.fwd_act[DIR_DOWN]  = (!i_btn[DIR_DOWN]  && i_sw) || below[1];
        ctl_in.fwd_act[DIR_UP]    = (!i_btn[DIR_UP]    && i_sw) || above[1];
        ctl_in.rev_ok[DIR_LEFT]   = i_btn[DIR_LEFT]  && mid[0];
        ctl_in.rev_ok[DIR_RIGHT]  = i_btn[DIR_RIGHT] && mid[0];
        ctl_in.rev_ok[DIR_DOWN]   = i_btn[DIR_DOWN]  && mid[1];
        ctl_in.rev_ok[DIR_UP]     = i_btn[DIR_UP]    && mid[1];
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            y[k]     = WY'(r_u[k]) * $signed(WY'(SCALE));
            hm[k]    = WM'(r_xh[k]) * $signed(WM'(SCALE));
            prod[k]  = WP'(r_abs[k]) * WP'(RECIP_633);
            s_pos[k] = $signed({1'b0, prod[k][WP-1:RECIP_SHIFT]});
            s[k]     = r_neg[k] ? -s_pos[k] : s_pos[k];
            dd[k]    = $signed(WM'(S_BIAS)) - WM'(r_s[k]);
            lm[k]    = dd[k] * $signed(WM'(SCALE));
            o_low_metric[k]  = r_lm[k];
            o_high_metric[k] = r_hm4[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl1 <= ctl_in;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            for (int k = 0; k < 2; k++) begin
                r_u[k]   <= $signed(u[k]);
                r_xh[k]  <= $signed(xh[k]);
                r_neg[k] <= y[k][WY-1];
                r_abs[k] <= WA'(y[k][WY-1] ? -y[k] : y[k]);
                r_hm2[k] <= hm[k];
                r_s[k]   <= s[k];
                r_hm3[k] <= r_hm2[k];
                r_lm[k]  <= lm[k];
                r_hm4[k] <= r_hm3[k];
            end
        end
    end

endmodule

>>> rtl/core/jqp_back.sv
// back end: direction counters, burst planning, one burst per cycle to a free output register
module jqp_back #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 8,
    localparam int WU = ((SAMPLE_BITS > jqp_pkg::DEAD_W) ? SAMPLE_BITS : jqp_pkg::DEAD_W) + 2,
    localparam int WM = WU + 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [jqp_pkg::CAP_W-1:0]  i_pulse_cap,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  jqp_pkg::t_ctl              i_ctl,
    input  logic [1:0][WM-1:0]         i_low_metric,
    input  logic [1:0][WM-1:0]         i_high_metric,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic                       o_axis,
    output logic                       o_lead_phase,
    output logic [jqp_pkg::CAP_W-1:0]  o_pulse_count,
    output logic                       o_last
);
    import jqp_pkg::*;

    localparam int CW = ((WM > COUNT_BITS + 11) ? WM : COUNT_BITS + 11) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_cnt [NDIR];
    logic [COUNT_BITS-1:0] n_cnt [NDIR];
    logic [CAP_W-1:0]      r_k [NDIR];
    logic [CAP_W-1:0]      kk [NDIR];
    logic [NSLOT-1:0]      r_mask;
    logic [NSLOT-1:0]      rest;

    logic [WM-1:0]         m [NDIR];
    logic signed [CW-1:0]  lhs [NDIR];
    logic [CW-1:0]         rhs [NDIR];
    logic [COUNT_BITS-1:0] cap_x;
    logic [NDIR-1:0]       below_cap;
    logic [NDIR-1:0]       fwd;
    logic [NDIR-1:0]       rev_emit;

    logic                  plan;
    logic                  emit;
    logic                  emit_last;
    logic                  out_free;
    logic [SLOT_W-1:0]     pick;
    logic [1:0]            dir;

    logic                  r_ovld;
    logic                  r_axis;
    logic                  r_lead;
    logic [CAP_W-1:0]      r_pcnt;
    logic                  r_last;

    assign m[DIR_LEFT]  = i_low_metric[0];
    assign m[DIR_RIGHT] = i_high_metric[0];
    assign m[DIR_DOWN]  = i_low_metric[1];
    assign m[DIR_UP]    = i_high_metric[1];
    assign cap_x        = COUNT_BITS'(i_pulse_cap);

    // counter below target is checked as metric >= den * (count + 1)
    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            lhs[d] = CW'($signed(m[d]));
            rhs[d] = (CW'(r_cnt[d]) + CW'(1)) * CW'((d % 2 == 1) ? HIGH_DEN : LOW_DEN);
            below_cap[d] = r_cnt[d] < cap_x;
            fwd[d] = i_ctl.fwd_act[d] &&
                     ((lhs[d] >= $signed(rhs[d])) || (below_cap[d] && i_ctl.sw));
            kk[d] = below_cap[d] ? CAP_W'(r_cnt[d]) : i_pulse_cap;
            rev_emit[d] = i_ctl.rev_ok[d] && (kk[d] != '0);
            if (fwd[d]) begin
                n_cnt[d] = (r_cnt[d] == CNT_MAX) ? r_cnt[d] : r_cnt[d] + 1'b1;
            end else if (i_ctl.rev_ok[d]) begin
                n_cnt[d] = '0;
            end else begin
                n_cnt[d] = r_cnt[d];
            end
        end
    end

    // forward slots come first, then reverse slots, each in direction order
    always_comb begin
        pick = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = SLOT_W'(i);
            end
        end
        rest       = r_mask;
        rest[pick] = 1'b0;
        emit_last  = (rest == '0);
        dir        = pick[1:0];
    end

    assign out_free = !r_ovld || i_pop;
    assign emit     = (r_mask != '0) && out_free;
    assign plan     = i_q_valid && (r_mask == '0);
    assign o_q_pop  = plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_ovld <= 1'b0;
            for (int d = 0; d < NDIR; d++) begin
                r_cnt[d] <= '0;
            end
        end else begin
            if (plan) begin
                r_mask <= {rev_emit, fwd};
                for (int d = 0; d < NDIR; d++) begin
                    r_cnt[d] <= n_cnt[d];
                end
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (plan) begin
            for (int d = 0; d < NDIR; d++) begin
                r_k[d] <= kk[d];
            end
        end
        if (emit) begin
            r_axis <= dir[1];
            r_lead <= dir[0] ^ pick[2];
            r_pcnt <= pick[2] ? r_k[dir] : CAP_W'(1);
            r_last <= emit_last;
        end
    end

    assign o_empty       = !r_ovld;
    assign o_axis        = r_axis;
    assign o_lead_phase  = r_lead;
    assign o_pulse_count = r_pcnt;
    assign o_last        = r_last;

    a_beat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_pulse_count != '0))
        else $error("burst beat with zero pulse count");

    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_last) |=> (r_mask != '0))
        else $error("bursts lost after a beat not marked last");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> ((r_mask == '0) && !o_empty))
        else $error("bursts left over after a beat marked last");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[DIR_LEFT] == CNT_MAX) |=>
            ((r_cnt[DIR_LEFT] == CNT_MAX) || (r_cnt[DIR_LEFT] == '0)))
        else $error("left counter wrapped past its maximum");

endmodule

>>> rtl/core/joystick_quadrature_pulse_planner_core.sv
// Joystick quadrature pulse planner: one polling pass in, up to four bursts out.
// A pass enters the four-stage classify pipeline in any cycle in which full is low
// and moves through the stage registers into the four-entry queue. The back end takes
// one pass from the queue per planning cycle, only once no burst of the previous pass
// is left, and then sends one burst per cycle while the output register is free; a
// pass gives 0 to 4 bursts. Bursts of a pass come out in order, the final one with
// last set. Registers are written through the cfg channel, which is always ready:
// index 0 dead_low, 1 dead_high, 2 pulse_cap; other indexes are ignored.
module joystick_quadrature_pulse_planner_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jqp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jqp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [SAMPLE_BITS-1:0]          i_vert_sample,
    input  logic [SAMPLE_BITS-1:0]          i_horiz_sample,
    input  logic                            i_left_button,
    input  logic                            i_right_button,
    input  logic                            i_down_button,
    input  logic                            i_up_button,
    input  logic                            i_mode_switch,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_axis,
    output logic                            o_lead_phase,
    output logic [jqp_pkg::CAP_W-1:0]       o_pulse_count,
    output logic                            o_last
);
    import jqp_pkg::*;

    localparam int WU = ((SAMPLE_BITS > DEAD_W) ? SAMPLE_BITS : DEAD_W) + 2;
    localparam int WM = WU + 7;
    localparam int QW = CTL_W + 4 * WM;

    t_cfg              r_cfg;
    t_cfg              n_cfg;

    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;

    t_ctl              f_ctl;
    logic [1:0][WM-1:0] f_low;
    logic [1:0][WM-1:0] f_high;
    t_ctl              b_ctl;
    logic [1:0][WM-1:0] b_low;
    logic [1:0][WM-1:0] b_high;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEAD_LOW:  n_cfg.dead_low  = i_cfg_data;
                CFG_DEAD_HIGH: n_cfg.dead_high = i_cfg_data;
                CFG_PULSE_CAP: n_cfg.pulse_cap = i_cfg_data[CAP_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_low  <= DEAD_LOW_RST;
            r_cfg.dead_high <= DEAD_HIGH_RST;
            r_cfg.pulse_cap <= PULSE_CAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    jqp_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_vert        (i_vert_sample),
        .i_horiz       (i_horiz_sample),
        .i_btn         ({i_up_button, i_down_button, i_right_button, i_left_button}),
        .i_sw          (i_mode_switch),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_ctl         (f_ctl),
        .o_low_metric  (f_low),
        .o_high_metric (f_high)
    );

    assign q_wdata = {f_ctl, f_low, f_high};

    jqp_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_ctl, b_low, b_high} = q_rdata;

    jqp_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pulse_cap   (r_cfg.pulse_cap),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_ctl         (b_ctl),
        .i_low_metric  (b_low),
        .i_high_metric (b_high),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_axis        (o_axis),
        .o_lead_phase  (o_lead_phase),
        .o_pulse_count (o_pulse_count),
        .o_last        (o_last)
    );

endmodule
